[rtl/core/dctq_pkg.sv]
// ----------------------------------------------------------------------------
// dctq_pkg
// Shared types, sizes and the fixed-point DCT basis for the 8x8 quantizer.
// ----------------------------------------------------------------------------
package dctq_pkg;

    localparam int BLOCK_DIM       = 8;
    localparam int BASIS_FRAC_BITS = 14;
    localparam int BLOCK_AREA      = BLOCK_DIM * BLOCK_DIM;
    localparam int UW              = $clog2(BLOCK_DIM);
    localparam int AW              = $clog2(BLOCK_AREA);
    localparam int BW              = BASIS_FRAC_BITS + 2;
    localparam int TW              = 8 + BASIS_FRAC_BITS + UW + 1;
    localparam int PW              = TW + BW;
    localparam int YW              = PW + UW;
    localparam int NW              = $clog2(255 * BLOCK_DIM + 2) + 1;
    localparam int QDEPTH          = 4;
    localparam int QAW             = $clog2(QDEPTH);
    localparam int COEF_MAX        = 2047;
    localparam int COEF_MIN_MAG    = 2048;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;
    localparam logic TOK_LOAD  = 1'b0;
    localparam logic TOK_BLOCK = 1'b1;

    typedef struct packed {
        logic          kind;
        logic          bank;
        logic [AW-1:0] index;
        logic [7:0]    step;
    } token_t;

    typedef struct packed {
        logic          bank;
        logic [AW-1:0] index;
    } pix_addr_t;

    typedef struct packed {
        logic en;
        logic bank;
    } bank_rel_t;

    typedef logic signed [BW-1:0] basis_tbl_t [BLOCK_AREA];

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v     = v_in;
        res   = 64'd0;
        bit_w = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (bit_w > v)
                bit_w = bit_w >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bit_w != 64'd0)
            begin
                if (v >= res + bit_w)
                begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
        end
        return res;
    endfunction

    function automatic longint cos_q30(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (64'd3373259426 * 64'(k)) / 64'(2 * BLOCK_DIM);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(64'd1 << 30);
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return sum;
    endfunction

    function automatic basis_tbl_t build_basis();
        basis_tbl_t  tbl;
        int          m;
        longint      c;
        longint      val;
        logic [63:0] alpha;
        logic [63:0] mag;
        logic [63:0] p;
        int          shift;
        shift = 60 - BASIS_FRAC_BITS;
        for (int u = 0; u < BLOCK_DIM; u++)
        begin
            alpha = isqrt64(((u == 0) ? (64'd1 << 60) : (64'd2 << 60)) / 64'(BLOCK_DIM));
            for (int k = 0; k < BLOCK_DIM; k++)
            begin
                m = ((2 * k + 1) * u) % (4 * BLOCK_DIM);
                if (m <= BLOCK_DIM)
                    c = cos_q30(m);
                else if (m <= 2 * BLOCK_DIM)
                    c = -cos_q30(2 * BLOCK_DIM - m);
                else if (m <= 3 * BLOCK_DIM)
                    c = -cos_q30(m - 2 * BLOCK_DIM);
                else
                    c = cos_q30(4 * BLOCK_DIM - m);
                mag = (c < 0) ? 64'(-c) : 64'(c);
                p   = alpha * mag;
                p   = (p + (64'd1 << (shift - 1))) >> shift;
                val = (c < 0) ? -longint'(p) : longint'(p);
                tbl[u * BLOCK_DIM + k] = val[BW-1:0];
            end
        end
        return tbl;
    endfunction

    localparam basis_tbl_t BASIS = build_basis();

endpackage

[rtl/core/dctq_front.sv]
// ----------------------------------------------------------------------------
// dctq_front
// Accepts requests, stores pixels into two block banks and queues tokens.
// ----------------------------------------------------------------------------
module dctq_front
    import dctq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       command,
    input  logic [5:0] table_index,
    input  logic [7:0] quant_step,
    input  logic [7:0] pixel,
    input  logic       q_full,
    input  bank_rel_t  rel,
    input  pix_addr_t  rd_addr,
    output logic [7:0] rd_data,
    output logic       busy,
    output logic       push,
    output token_t     push_tok
);

    logic [AW-1:0] pixel_count_reg, pixel_count_next;
    logic          wr_bank_reg, wr_bank_next;
    logic [1:0]    bank_busy_reg, bank_busy_next;
    logic [7:0]    pix_mem [2*BLOCK_AREA];
    logic          accept;
    logic          is_pixel;
    logic          block_end;

    assign busy      = q_full | bank_busy_reg[wr_bank_reg];
    assign accept    = start & ~busy;
    assign is_pixel  = (command == CMD_PIXEL);
    assign block_end = is_pixel && (pixel_count_reg == AW'(BLOCK_AREA - 1));
    assign push      = accept & (~is_pixel | block_end);

    always_comb
    begin
        push_tok.kind  = is_pixel ? TOK_BLOCK : TOK_LOAD;
        push_tok.bank  = wr_bank_reg;
        push_tok.index = table_index[AW-1:0];
        push_tok.step  = (quant_step == 8'd0) ? 8'd1 : quant_step;
    end

    always_comb
    begin
        pixel_count_next = pixel_count_reg;
        wr_bank_next     = wr_bank_reg;
        bank_busy_next   = bank_busy_reg;
        if (rel.en)
            bank_busy_next[rel.bank] = 1'b0;
        if (accept && is_pixel)
        begin
            if (block_end)
            begin
                pixel_count_next            = '0;
                wr_bank_next                = ~wr_bank_reg;
                bank_busy_next[wr_bank_reg] = 1'b1;
            end
            else
            begin
                pixel_count_next = pixel_count_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= '0;
            wr_bank_reg     <= 1'b0;
            bank_busy_reg   <= '0;
        end
        else
        begin
            pixel_count_reg <= pixel_count_next;
            wr_bank_reg     <= wr_bank_next;
            bank_busy_reg   <= bank_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_pixel)
            pix_mem[{wr_bank_reg, pixel_count_reg}] <= pixel;
        rd_data <= pix_mem[{rd_addr.bank, rd_addr.index}];
    end

endmodule

[rtl/core/dctq_queue.sv]
// ----------------------------------------------------------------------------
// dctq_queue
// Short token FIFO between front and back.
// ----------------------------------------------------------------------------
module dctq_queue
    import dctq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t push_tok,
    input  logic   pop,
    output token_t head_tok,
    output logic   empty,
    output logic   full
);

    logic [QAW:0]   count_reg, count_next;
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    token_t         slots [QDEPTH];
    logic           do_push;
    logic           do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (QAW+1)'(QDEPTH));
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign head_tok = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_tok;
    end

endmodule

[rtl/core/dctq_back.sv]
// ----------------------------------------------------------------------------
// dctq_back
// Runs table loads and block jobs: row pass, column pass, rounding divide.
// ----------------------------------------------------------------------------
module dctq_back
    import dctq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  token_t            head_tok,
    output logic              pop,
    output pix_addr_t         rd_addr,
    input  logic [7:0]        rd_data,
    output bank_rel_t         rel,
    output logic              valid,
    output logic signed [11:0] coefficient,
    output logic [5:0]        position,
    output logic              last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROW  = 3'd1;
    localparam logic [2:0] ST_COL  = 3'd2;
    localparam logic [2:0] ST_ABS  = 3'd3;
    localparam logic [2:0] ST_RND  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam int         CW      = $clog2(NW);

    function automatic logic [AW-1:0] flat(input logic [UW-1:0] r, input logic [UW-1:0] c);
        return AW'(int'(r) * BLOCK_DIM + int'(c));
    endfunction

    logic [2:0]           state_reg, state_next;
    logic                 bank_reg, bank_next;
    logic [UW-1:0]        u_reg, u_next;
    logic [UW-1:0]        v_reg, v_next;
    logic [UW-1:0]        k_reg, k_next;
    logic                 issuing_reg, issuing_next;
    logic                 s1_reg, s1_next;
    logic                 s1_last_reg, s1_last_next;
    logic                 s2_reg, s2_next;
    logic                 s2_last_reg, s2_last_next;
    logic signed [YW-1:0] acc_reg, acc_next;
    logic signed [YW-1:0] y_reg, y_next;
    logic                 neg_reg, neg_next;
    logic [YW-1:0]        mag_reg, mag_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [8:0]           rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 valid_reg, valid_next;
    logic signed [11:0]   coef_reg, coef_next;
    logic [5:0]           pos_reg, pos_next;
    logic                 last_reg, last_next;

    logic signed [BW-1:0] b_reg;
    logic signed [TW-1:0] t_rd_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [TW-1:0] t_mem [BLOCK_AREA];
    logic [7:0]           q_mem [BLOCK_AREA];
    logic [BLOCK_AREA-1:0] qvalid_reg;
    logic [7:0]           q_rd_reg;
    logic                 qv_rd_reg;
    logic [7:0]           q_eff;

    logic                 t_we;
    logic                 q_we;
    logic [AW-1:0]        bidx;
    logic [AW-1:0]        taddr;
    logic [AW-1:0]        elem;
    logic signed [TW-1:0] op_a;
    logic signed [PW-1:0] prod;
    logic signed [YW-1:0] acc_sum;
    logic [8:0]           trial;
    logic                 ge;
    logic [NW-1:0]        quo;
    logic                 elem_last;

    assign elem      = flat(u_reg, v_reg);
    assign elem_last = (u_reg == UW'(BLOCK_DIM - 1)) && (v_reg == UW'(BLOCK_DIM - 1));
    assign bidx      = (state_reg == ST_COL) ? flat(v_reg, k_reg) : flat(u_reg, k_reg);
    assign taddr     = flat(u_reg, k_reg);
    assign rd_addr.bank  = bank_reg;
    assign rd_addr.index = flat(k_reg, v_reg);
    assign op_a      = (state_reg == ST_COL) ? t_rd_reg : TW'($signed({1'b0, rd_data}));
    assign prod      = op_a * b_reg;
    assign acc_sum   = acc_reg + YW'(prod_reg);
    assign q_eff     = qv_rd_reg ? q_rd_reg : 8'd1;
    assign trial     = {rem_reg[7:0], n_reg[NW-1]};
    assign ge        = (trial >= {1'b0, q_eff});
    assign quo       = {n_reg[NW-2:0], ge};
    assign q_we      = pop && (head_tok.kind == TOK_LOAD);

    always_comb
    begin
        state_next   = state_reg;
        bank_next    = bank_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        k_next       = k_reg;
        issuing_next = issuing_reg;
        s1_next      = issuing_reg && (state_reg == ST_ROW || state_reg == ST_COL);
        s1_last_next = issuing_reg && (k_reg == UW'(BLOCK_DIM - 1));
        s2_next      = s1_reg;
        s2_last_next = s1_last_reg;
        acc_next     = acc_reg;
        y_next       = y_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        n_next       = n_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        valid_next   = 1'b0;
        coef_next    = coef_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        pop          = 1'b0;
        t_we         = 1'b0;
        rel.en       = 1'b0;
        rel.bank     = bank_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head_tok.kind == TOK_BLOCK)
                    begin
                        bank_next    = head_tok.bank;
                        u_next       = '0;
                        v_next       = '0;
                        k_next       = '0;
                        acc_next     = '0;
                        issuing_next = 1'b1;
                        state_next   = ST_ROW;
                    end
                end
            end
            ST_ROW, ST_COL:
            begin
                if (issuing_reg)
                begin
                    if (k_reg == UW'(BLOCK_DIM - 1))
                    begin
                        k_next       = '0;
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        k_next = k_reg + UW'(1);
                    end
                end
                if (s2_reg)
                begin
                    if (s2_last_reg)
                    begin
                        acc_next = '0;
                        if (state_reg == ST_ROW)
                        begin
                            t_we         = 1'b1;
                            issuing_next = 1'b1;
                            if (elem_last)
                            begin
                                u_next     = '0;
                                v_next     = '0;
                                rel.en     = 1'b1;
                                state_next = ST_COL;
                            end
                            else if (v_reg == UW'(BLOCK_DIM - 1))
                            begin
                                v_next = '0;
                                u_next = u_reg + UW'(1);
                            end
                            else
                            begin
                                v_next = v_reg + UW'(1);
                            end
                        end
                        else
                        begin
                            y_next     = acc_sum;
                            state_next = ST_ABS;
                        end
                    end
                    else
                    begin
                        acc_next = acc_sum;
                    end
                end
            end
            ST_ABS:
            begin
                neg_next   = y_reg[YW-1];
                mag_next   = y_reg[YW-1] ? YW'(-y_reg) : YW'(y_reg);
                state_next = ST_RND;
            end
            ST_RND:
            begin
                n_next     = NW'((mag_reg + (YW'(q_eff) << (2 * BASIS_FRAC_BITS - 1)))
                                 >> (2 * BASIS_FRAC_BITS));
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = ge ? (trial - {1'b0, q_eff}) : trial;
                n_next   = quo;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1))
                begin
                    valid_next = 1'b1;
                    pos_next   = 6'(elem);
                    last_next  = elem_last;
                    if (neg_reg)
                        coef_next = (int'(quo) > COEF_MIN_MAG) ? 12'sh800 : 12'(-int'(quo));
                    else
                        coef_next = (int'(quo) > COEF_MAX) ? 12'sh7FF : 12'(quo);
                    if (elem_last)
                    begin
                        u_next     = '0;
                        v_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        issuing_next = 1'b1;
                        state_next   = ST_COL;
                        if (v_reg == UW'(BLOCK_DIM - 1))
                        begin
                            v_next = '0;
                            u_next = u_reg + UW'(1);
                        end
                        else
                        begin
                            v_next = v_reg + UW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bank_reg    <= 1'b0;
            u_reg       <= '0;
            v_reg       <= '0;
            k_reg       <= '0;
            issuing_reg <= 1'b0;
            s1_reg      <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_reg      <= 1'b0;
            s2_last_reg <= 1'b0;
            cnt_reg     <= '0;
            valid_reg   <= 1'b0;
            qvalid_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bank_reg    <= bank_next;
            u_reg       <= u_next;
            v_reg       <= v_next;
            k_reg       <= k_next;
            issuing_reg <= issuing_next;
            s1_reg      <= s1_next;
            s1_last_reg <= s1_last_next;
            s2_reg      <= s2_next;
            s2_last_reg <= s2_last_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
            if (q_we)
                qvalid_reg[head_tok.index] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        y_reg    <= y_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        coef_reg <= coef_next;
        pos_reg  <= pos_next;
        last_reg <= last_next;
        b_reg    <= BASIS[bidx];
        prod_reg <= prod;
        t_rd_reg <= t_mem[taddr];
        if (t_we)
            t_mem[elem] <= TW'(acc_sum);
        if (q_we)
            q_mem[head_tok.index] <= head_tok.step;
        q_rd_reg  <= q_mem[elem];
        qv_rd_reg <= qvalid_reg[elem];
    end

    assign valid       = valid_reg;
    assign coefficient = coef_reg;
    assign position    = pos_reg;
    assign last        = last_reg;

endmodule

[rtl/core/dct8x8_quantizer.sv]
// ----------------------------------------------------------------------------
// dct8x8_quantizer
// 8x8 orthonormal 2-D DCT with per-position rounding quantization.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// request   in         start & !busy      command, table_index, quant_step, pixel
// result    out        valid (one cycle)  coefficient, position, last
//
// Loads and pixels are taken on start & !busy, back to back while busy is low.
// Each block job runs in the shared multiply-accumulate unit: a row pass
// over all elements first, then for each element a column pass and the
// 12-step divider; one result comes out per element, after its divide.
// Two pixel banks let the next block load while one is transformed; busy
// rises when the token queue is full or the bank to be written is in use.
// Reset clears all control and the quantization table to all ones at once.
// ----------------------------------------------------------------------------
module dct8x8_quantizer
    import dctq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               command,
    input  logic [5:0]         table_index,
    input  logic [7:0]         quant_step,
    input  logic [7:0]         pixel,
    output logic               valid,
    output logic signed [11:0] coefficient,
    output logic [5:0]         position,
    output logic               last
);

    logic      push;
    token_t    push_tok;
    token_t    head_tok;
    logic      pop;
    logic      empty;
    logic      full;
    pix_addr_t rd_addr;
    logic [7:0] rd_data;
    bank_rel_t rel;

    dctq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .table_index (table_index),
        .quant_step  (quant_step),
        .pixel       (pixel),
        .q_full      (full),
        .rel         (rel),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .busy        (busy),
        .push        (push),
        .push_tok    (push_tok)
    );

    dctq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .head_tok (head_tok),
        .empty    (empty),
        .full     (full)
    );

    dctq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head_tok    (head_tok),
        .pop         (pop),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .rel         (rel),
        .valid       (valid),
        .coefficient (coefficient),
        .position    (position),
        .last        (last)
    );

endmodule

[rtl/core/dctq_checker.sv]
// ----------------------------------------------------------------------------
// dctq_port_props
// Port-level checks on the result strobe of the quantizer.
// ----------------------------------------------------------------------------
module dctq_port_props
(
    input logic               clk,
    input logic               rst_n,
    input logic               valid,
    input logic signed [11:0] coefficient,
    input logic [5:0]         position,
    input logic               last
);

    a_last_pos : assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (last == (position == 6'd63)))
        else $error("last does not match final position");

    a_spacing : assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("results on adjacent cycles");

    a_block_gap : assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |=> !valid ##1 !valid ##1 !valid)
        else $error("result too soon after end of block");

    a_pos_known : assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !$isunknown({coefficient, position, last}))
        else $error("unknown result fields");

endmodule

bind dct8x8_quantizer dctq_port_props u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (valid),
    .coefficient (coefficient),
    .position    (position),
    .last        (last)
);
